/* rtl/nrmc_pkg.sv */
// Shared types, character codes and scaling constants for the RMC sentence parser.
// Used by nrmc_byte_parser, nrmc_coord_convert and nmea_rmc_sentence_parser_unit.
// No dependencies.
package nrmc_pkg;

    // Character codes seen in the byte stream.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SOUTH  = 8'h53;
    localparam logic [7:0] CH_WEST   = 8'h57;

    // Field numbers within a sentence.
    localparam logic [3:0] FLD_TAG    = 4'd0;
    localparam logic [3:0] FLD_TIME   = 4'd1;
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT    = 4'd3;
    localparam logic [3:0] FLD_NS     = 4'd4;
    localparam logic [3:0] FLD_LON    = 4'd5;
    localparam logic [3:0] FLD_EW     = 4'd6;
    localparam logic [3:0] FLD_SPEED  = 4'd7;
    localparam logic [3:0] FLD_COURSE = 4'd8;
    localparam logic [3:0] FLD_DATE   = 4'd9;
    localparam logic [3:0] FLD_MODE   = 4'd12;
    localparam logic [3:0] FLD_LAST   = 4'd15;

    // Checksum capture counts.
    localparam logic [1:0] CHK_HIGH = 2'd2;
    localparam logic [1:0] CHK_LOW  = 2'd1;
    localparam logic [1:0] CHK_NONE = 2'd0;

    localparam int TAG_LEN     = 5;
    localparam int BCD_DIGITS  = 6;
    localparam int LAT_DEG_CH  = 2;
    localparam int LON_DEG_CH  = 3;
    localparam int MIN_FRAC    = 4;
    localparam int CENTI_FRAC  = 2;

    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int LAT_W     = 31;
    localparam int LON_W     = 35;
    localparam int MIN_W     = 20;
    localparam int CENTI_W   = 16;

    localparam logic [MIN_W-1:0]   MIN_MAX   = 20'hFFFFF;
    localparam logic [CENTI_W-1:0] CENTI_MAX = 16'hFFFF;

    // Degrees times 1e7 plus minutes_e4 * 1000 / 60 = minutes_e4 * 50 / 3.
    localparam int          DEG_SCALE = 10000000;
    localparam int          MIN_MULT  = 50;
    localparam int          M50_W     = 26;
    localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;
    localparam int          RECIP_SH  = 33;
    localparam int          QUOT_W    = 25;

    localparam int TDATA_W = 184;

    // Snapshot of everything a record needs, taken at the line feed.
    typedef struct packed {
        logic                 tag;
        logic [23:0]          time_bcd;
        logic [7:0]           status;
        logic [LAT_DEG_W-1:0] lat_deg;
        logic [MIN_W-1:0]     lat_min;
        logic                 lat_south;
        logic [LON_DEG_W-1:0] lon_deg;
        logic [MIN_W-1:0]     lon_min;
        logic                 lon_west;
        logic [CENTI_W-1:0]   speed;
        logic [CENTI_W-1:0]   course;
        logic [23:0]          date_bcd;
        logic [7:0]           mode;
        logic [15:0]          checksum;
    } rec_t;

    // Result of one decimal accumulation step.
    typedef struct packed {
        logic [MIN_W-1:0] acc;
        logic             seen;
        logic [2:0]       frac;
    } acc_step_t;

    function automatic logic [3:0] digit_of(input logic [7:0] b);
        digit_of = (b >= CH_ZERO && b <= CH_NINE) ? 4'(b - CH_ZERO) : 4'd0;
    endfunction

    function automatic logic [7:0] tag_char(input logic [2:0] p);
        unique case (p)
            3'd0:    tag_char = 8'h47;
            3'd1:    tag_char = 8'h50;
            3'd2:    tag_char = 8'h52;
            3'd3:    tag_char = 8'h4D;
            default: tag_char = 8'h43;
        endcase
    endfunction

    // Weight of the n-th minutes fraction digit, in units of 1e-4 minute.
    function automatic logic [9:0] frac_scale(input logic [1:0] n);
        unique case (n)
            2'd0:    frac_scale = 10'd1000;
            2'd1:    frac_scale = 10'd100;
            2'd2:    frac_scale = 10'd10;
            default: frac_scale = 10'd1;
        endcase
    endfunction

    // Date characters ddmmyy land in month-day-year digit order.
    function automatic logic [2:0] date_slot(input logic [2:0] p);
        unique case (p)
            3'd0:    date_slot = 3'd2;
            3'd1:    date_slot = 3'd3;
            3'd2:    date_slot = 3'd0;
            3'd3:    date_slot = 3'd1;
            3'd4:    date_slot = 3'd4;
            default: date_slot = 3'd5;
        endcase
    endfunction

endpackage

/* rtl/nmea_rmc_sentence_parser_unit.sv */
// Each record is registered in the snapshot, products, divide and output stages in turn.
// Throughput: one byte beat per cycle; records pass a four-deep pipeline (snapshot, products,
// divide, output register), so s_tready falls only when all four hold records and m_tready is low.
// Reset: synchronous, active-low aresetn clears the sentence state and all pipeline valids.
// Depends on nrmc_pkg, nrmc_byte_parser and nrmc_coord_convert.
module nmea_rmc_sentence_parser_unit
    import nrmc_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // data_byte [7:0]
    input  logic [7:0]         s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // sentence_is_rmc [0], utc_time_bcd [24:1], fix_status [32:25], latitude [63:33],
    // longitude [98:64], speed_centiknots [114:99], course_centidegrees [130:115],
    // date_bcd [154:131], mode_indicator [162:155], checksum_chars [178:163], zero pad
    output logic [TDATA_W-1:0] m_tdata
);

    logic               s_accept;
    logic               rec_valid;
    rec_t               rec;
    logic               s1_v_reg, s1_v_next;
    rec_t               s1_reg;
    logic               s2_v_reg, s2_v_next;
    rec_t               s2_reg;
    logic               s3_v_reg, s3_v_next;
    rec_t               s3_reg;
    logic               out_v_reg, out_v_next;
    logic [TDATA_W-1:0] tdata_reg, tdata_next;
    logic               rdy1, rdy2, rdy3;
    logic [LAT_W-1:0]   lat_coord;
    logic [LON_W-1:0]   lon_coord;

    // Stage can take a record when empty or when its contents move on.
    always_comb begin
        rdy3     = !out_v_reg || m_tready;
        rdy2     = !s3_v_reg || rdy3;
        rdy1     = !s2_v_reg || rdy2;
        s_tready = !s1_v_reg || rdy1;
        s_accept = s_tvalid && s_tready;
    end

    nrmc_byte_parser #(
        .MAX_FIELD_CHARS(MAX_FIELD_CHARS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_accept(s_accept),
        .beat_byte  (s_tdata),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    nrmc_coord_convert #(
        .DEG_W(LAT_DEG_W),
        .OUT_W(LAT_W)
    ) u_lat_conv (
        .aclk     (aclk),
        .load_mult(rdy1 && s1_v_reg),
        .load_div (rdy2 && s2_v_reg),
        .deg      (s1_reg.lat_deg),
        .minutes  (s1_reg.lat_min),
        .negative (s1_reg.lat_south),
        .coord    (lat_coord)
    );

    nrmc_coord_convert #(
        .DEG_W(LON_DEG_W),
        .OUT_W(LON_W)
    ) u_lon_conv (
        .aclk     (aclk),
        .load_mult(rdy1 && s1_v_reg),
        .load_div (rdy2 && s2_v_reg),
        .deg      (s1_reg.lon_deg),
        .minutes  (s1_reg.lon_min),
        .negative (s1_reg.lon_west),
        .coord    (lon_coord)
    );

    // Pipeline valid tracking.
    always_comb begin
        s1_v_next  = rec_valid ? 1'b1 : (rdy1 ? 1'b0 : s1_v_reg);
        s2_v_next  = rdy1 ? s1_v_reg : s2_v_reg;
        s3_v_next  = rdy2 ? s2_v_reg : s3_v_reg;
        out_v_next = rdy3 ? s3_v_reg : out_v_reg;
    end

    // Output beat assembly.
    always_comb begin
        tdata_next = {5'b0, s3_reg.checksum, s3_reg.mode, s3_reg.date_bcd, s3_reg.course,
                      s3_reg.speed, lon_coord, lat_coord, s3_reg.status, s3_reg.time_bcd,
                      s3_reg.tag};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            s3_v_reg  <= s3_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Record payload moves with its valid bit.
    always_ff @(posedge aclk) begin
        if (rec_valid) begin
            s1_reg <= rec;
        end
        if (rdy1 && s1_v_reg) begin
            s2_reg <= s1_reg;
        end
        if (rdy2 && s2_v_reg) begin
            s3_reg <= s2_reg;
        end
        if (rdy3 && s3_v_reg) begin
            tdata_reg <= tdata_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = tdata_reg;

    // The input stalls only when every stage holds a record and the output is held.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && s1_v_reg && s2_v_reg && s3_v_reg))
        else $error("input stalled while the record pipeline had room");

    // Records start only from an accepted line feed beat.
    a_record_from_lf: assert property (@(posedge aclk) disable iff (!aresetn)
        rec_valid |-> (s_tvalid && s_tready && s_tdata == CH_LF))
        else $error("record started without an accepted line feed");

    // A new output beat always comes from the divide stage.
    a_out_from_stage3: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s3_v_reg))
        else $error("output beat appeared without a record in the last stage");

    // A blocked snapshot stage keeps its record.
    a_s1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_v_reg && !rdy1) |=> s1_v_reg)
        else $error("snapshot record lost while the pipeline was stalled");

endmodule

/* rtl/nrmc_byte_parser.sv */
// Per-byte sentence state: field tracking and decoding of the RMC fields that a record carries.
// Emits a record snapshot on the line feed that closes a sentence.
// Depends on nrmc_pkg.
module nrmc_byte_parser
    import nrmc_pkg::*;
#(
    parameter int MAX_FIELD_CHARS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       beat_accept,
    input  logic [7:0] beat_byte,
    output logic       rec_valid,
    output rec_t       rec
);

    localparam int CPOS_W = $clog2(MAX_FIELD_CHARS + 1);

    logic                 in_sentence_reg, in_sentence_next;
    logic [3:0]           field_reg, field_next;
    logic [CPOS_W-1:0]    cpos_reg, cpos_next;
    logic                 tag_reg, tag_next;
    logic [23:0]          time_reg, time_next;
    logic [7:0]           status_reg, status_next;
    logic [LAT_DEG_W-1:0] lat_deg_reg, lat_deg_next;
    logic [MIN_W-1:0]     lat_min_reg, lat_min_next;
    logic                 lat_south_reg, lat_south_next;
    logic [LON_DEG_W-1:0] lon_deg_reg, lon_deg_next;
    logic [MIN_W-1:0]     lon_min_reg, lon_min_next;
    logic                 lon_west_reg, lon_west_next;
    logic [CENTI_W-1:0]   speed_reg, speed_next;
    logic [CENTI_W-1:0]   course_reg, course_next;
    logic [2:0]           frac_reg, frac_next;
    logic                 seen_reg, seen_next;
    logic [23:0]          date_reg, date_next;
    logic [7:0]           mode_reg, mode_next;
    logic [15:0]          chk_reg, chk_next;
    logic [1:0]           star_reg, star_next;

    // Minutes accumulate as minutes times 1e4, saturating at the 20-bit limit.
    function automatic acc_step_t min_step(input logic [MIN_W-1:0] m, input logic [7:0] b,
                                           input logic seen, input logic [2:0] frac);
        acc_step_t  r;
        logic [3:0]  d;
        logic [23:0] v;
        d      = digit_of(b);
        r.acc  = m;
        r.seen = seen;
        r.frac = frac;
        v      = '0;
        if (b == CH_POINT && !seen) begin
            r.seen = 1'b1;
        end else if (!seen) begin
            v     = 24'(m) * 24'd10 + 24'(d) * 24'd10000;
            r.acc = (v > 24'(MIN_MAX)) ? MIN_MAX : v[MIN_W-1:0];
        end else if (frac < 3'(MIN_FRAC)) begin
            v      = 24'(m) + 24'(d) * 24'(frac_scale(frac[1:0]));
            r.frac = frac + 3'd1;
            r.acc  = (v > 24'(MIN_MAX)) ? MIN_MAX : v[MIN_W-1:0];
        end
        min_step = r;
    endfunction

    // Speed and course accumulate in hundredths, saturating at 16 bits.
    function automatic acc_step_t centi_step(input logic [CENTI_W-1:0] a, input logic [7:0] b,
                                             input logic seen, input logic [2:0] frac);
        acc_step_t  r;
        logic [3:0]  d;
        logic [19:0] v;
        d      = digit_of(b);
        r.acc  = MIN_W'(a);
        r.seen = seen;
        r.frac = frac;
        v      = '0;
        if (b == CH_POINT && !seen) begin
            r.seen = 1'b1;
        end else if (!seen) begin
            v     = 20'(a) * 20'd10 + 20'(d) * 20'd100;
            r.acc = MIN_W'((v > 20'(CENTI_MAX)) ? CENTI_MAX : v[CENTI_W-1:0]);
        end else if (frac < 3'(CENTI_FRAC)) begin
            v      = 20'(a) + ((frac == 3'd0) ? 20'(d) * 20'd10 : 20'(d));
            r.frac = frac + 3'd1;
            r.acc  = MIN_W'((v > 20'(CENTI_MAX)) ? CENTI_MAX : v[CENTI_W-1:0]);
        end
        centi_step = r;
    endfunction

    // Next state for one accepted byte.
    always_comb begin
        acc_step_t  st;
        logic [3:0] d;
        logic       is_term;
        in_sentence_next = in_sentence_reg;
        field_next       = field_reg;
        cpos_next        = cpos_reg;
        tag_next         = tag_reg;
        time_next        = time_reg;
        status_next      = status_reg;
        lat_deg_next     = lat_deg_reg;
        lat_min_next     = lat_min_reg;
        lat_south_next   = lat_south_reg;
        lon_deg_next     = lon_deg_reg;
        lon_min_next     = lon_min_reg;
        lon_west_next    = lon_west_reg;
        speed_next       = speed_reg;
        course_next      = course_reg;
        frac_next        = frac_reg;
        seen_next        = seen_reg;
        date_next        = date_reg;
        mode_next        = mode_reg;
        chk_next         = chk_reg;
        star_next        = star_reg;
        rec_valid        = 1'b0;
        d                = digit_of(beat_byte);
        st               = '0;
        is_term          = (beat_byte == CH_LF) || (beat_byte == CH_COMMA)
                           || (beat_byte == CH_STAR);

        if (beat_accept) begin
            if (beat_byte == CH_DOLLAR) begin
                // Start of a sentence clears every accumulator.
                in_sentence_next = 1'b1;
                field_next       = '0;
                cpos_next        = '0;
                tag_next         = 1'b1;
                time_next        = '0;
                status_next      = '0;
                lat_deg_next     = '0;
                lat_min_next     = '0;
                lat_south_next   = 1'b0;
                lon_deg_next     = '0;
                lon_min_next     = '0;
                lon_west_next    = 1'b0;
                speed_next       = '0;
                course_next      = '0;
                frac_next        = '0;
                seen_next        = 1'b0;
                date_next        = '0;
                mode_next        = '0;
                chk_next         = '0;
                star_next        = CHK_NONE;
            end else if (in_sentence_reg && beat_byte != CH_CR) begin
                // A tag field that ends short cannot be GPRMC.
                if (is_term && field_reg == FLD_TAG && cpos_reg < CPOS_W'(TAG_LEN)) begin
                    tag_next = 1'b0;
                end
                priority if (beat_byte == CH_LF) begin
                    rec_valid        = 1'b1;
                    in_sentence_next = 1'b0;
                end else if (beat_byte == CH_COMMA) begin
                    if (field_reg != FLD_LAST) begin
                        field_next = field_reg + 4'd1;
                    end
                    cpos_next = '0;
                    frac_next = '0;
                    seen_next = 1'b0;
                    star_next = CHK_NONE;
                end else if (beat_byte == CH_STAR) begin
                    chk_next  = '0;
                    star_next = CHK_HIGH;
                end else if (star_reg != CHK_NONE) begin
                    // Checksum characters, first one into the upper byte.
                    if (star_reg == CHK_HIGH) begin
                        chk_next = chk_reg | {beat_byte, 8'h00};
                    end else begin
                        chk_next = chk_reg | {8'h00, beat_byte};
                    end
                    star_next = star_reg - 2'd1;
                end else if (cpos_reg < CPOS_W'(MAX_FIELD_CHARS)) begin
                    cpos_next = cpos_reg + CPOS_W'(1);
                    case (field_reg)
                        FLD_TAG: begin
                            if (cpos_reg < CPOS_W'(TAG_LEN)
                                && beat_byte != tag_char(cpos_reg[2:0])) begin
                                tag_next = 1'b0;
                            end
                        end
                        FLD_TIME: begin
                            for (int i = 0; i < BCD_DIGITS; i++) begin
                                if (cpos_reg == CPOS_W'(i)) begin
                                    time_next[4*(BCD_DIGITS-1-i) +: 4] =
                                        time_reg[4*(BCD_DIGITS-1-i) +: 4] | d;
                                end
                            end
                        end
                        FLD_STATUS: begin
                            if (cpos_reg == '0) begin
                                status_next = beat_byte;
                            end
                        end
                        FLD_LAT: begin
                            if (cpos_reg < CPOS_W'(LAT_DEG_CH)) begin
                                lat_deg_next = LAT_DEG_W'(lat_deg_reg * LAT_DEG_W'(10)
                                                          + LAT_DEG_W'(d));
                            end else begin
                                st           = min_step(lat_min_reg, beat_byte, seen_reg,
                                                        frac_reg);
                                lat_min_next = st.acc;
                                seen_next    = st.seen;
                                frac_next    = st.frac;
                            end
                        end
                        FLD_NS: begin
                            if (cpos_reg == '0) begin
                                lat_south_next = (beat_byte == CH_SOUTH);
                            end
                        end
                        FLD_LON: begin
                            if (cpos_reg < CPOS_W'(LON_DEG_CH)) begin
                                lon_deg_next = LON_DEG_W'(lon_deg_reg * LON_DEG_W'(10)
                                                          + LON_DEG_W'(d));
                            end else begin
                                st           = min_step(lon_min_reg, beat_byte, seen_reg,
                                                        frac_reg);
                                lon_min_next = st.acc;
                                seen_next    = st.seen;
                                frac_next    = st.frac;
                            end
                        end
                        FLD_EW: begin
                            if (cpos_reg == '0) begin
                                lon_west_next = (beat_byte == CH_WEST);
                            end
                        end
                        FLD_SPEED: begin
                            st         = centi_step(speed_reg, beat_byte, seen_reg, frac_reg);
                            speed_next = st.acc[CENTI_W-1:0];
                            seen_next  = st.seen;
                            frac_next  = st.frac;
                        end
                        FLD_COURSE: begin
                            st          = centi_step(course_reg, beat_byte, seen_reg, frac_reg);
                            course_next = st.acc[CENTI_W-1:0];
                            seen_next   = st.seen;
                            frac_next   = st.frac;
                        end
                        FLD_DATE: begin
                            for (int i = 0; i < BCD_DIGITS; i++) begin
                                if (cpos_reg == CPOS_W'(i)) begin
                                    date_next[4*(BCD_DIGITS-1-date_slot(3'(i))) +: 4] =
                                        date_reg[4*(BCD_DIGITS-1-date_slot(3'(i))) +: 4] | d;
                                end
                            end
                        end
                        FLD_MODE: begin
                            if (cpos_reg == '0) begin
                                mode_next = beat_byte;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    // Record snapshot; the tag flag includes the check made by this line feed.
    always_comb begin
        rec.tag       = tag_next;
        rec.time_bcd  = time_reg;
        rec.status    = status_reg;
        rec.lat_deg   = lat_deg_reg;
        rec.lat_min   = lat_min_reg;
        rec.lat_south = lat_south_reg;
        rec.lon_deg   = lon_deg_reg;
        rec.lon_min   = lon_min_reg;
        rec.lon_west  = lon_west_reg;
        rec.speed     = speed_reg;
        rec.course    = course_reg;
        rec.date_bcd  = date_reg;
        rec.mode      = mode_reg;
        rec.checksum  = chk_reg;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            field_reg       <= '0;
            cpos_reg        <= '0;
            tag_reg         <= 1'b0;
            time_reg        <= '0;
            status_reg      <= '0;
            lat_deg_reg     <= '0;
            lat_min_reg     <= '0;
            lat_south_reg   <= 1'b0;
            lon_deg_reg     <= '0;
            lon_min_reg     <= '0;
            lon_west_reg    <= 1'b0;
            speed_reg       <= '0;
            course_reg      <= '0;
            frac_reg        <= '0;
            seen_reg        <= 1'b0;
            date_reg        <= '0;
            mode_reg        <= '0;
            chk_reg         <= '0;
            star_reg        <= CHK_NONE;
        end else begin
            in_sentence_reg <= in_sentence_next;
            field_reg       <= field_next;
            cpos_reg        <= cpos_next;
            tag_reg         <= tag_next;
            time_reg        <= time_next;
            status_reg      <= status_next;
            lat_deg_reg     <= lat_deg_next;
            lat_min_reg     <= lat_min_next;
            lat_south_reg   <= lat_south_next;
            lon_deg_reg     <= lon_deg_next;
            lon_min_reg     <= lon_min_next;
            lon_west_reg    <= lon_west_next;
            speed_reg       <= speed_next;
            course_reg      <= course_next;
            frac_reg        <= frac_next;
            seen_reg        <= seen_next;
            date_reg        <= date_next;
            mode_reg        <= mode_next;
            chk_reg         <= chk_next;
            star_reg        <= star_next;
        end
    end

endmodule

/* rtl/nrmc_coord_convert.sv */
// Two-stage conversion of degrees and minutes_e4 to signed degrees times 1e7.
// Stage one forms the products, stage two divides by three with a reciprocal.
// Depends on nrmc_pkg.
module nrmc_coord_convert
    import nrmc_pkg::*;
#(
    parameter int DEG_W = 7,
    parameter int OUT_W = 31
) (
    input  logic             aclk,
    input  logic             load_mult,
    input  logic             load_div,
    input  logic [DEG_W-1:0] deg,
    input  logic [MIN_W-1:0] minutes,
    input  logic             negative,
    output logic [OUT_W-1:0] coord
);

    localparam int DP_W = DEG_W + 24;

    logic [OUT_W-1:0]  degp_reg, degp_next;
    logic [M50_W-1:0]  m50_reg, m50_next;
    logic              neg2_reg;
    logic [OUT_W-1:0]  degp3_reg;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic              neg3_reg;
    logic [M50_W+31:0] recip_prod;
    logic [OUT_W-1:0]  mag;

    // Degrees times 1e7 and minutes_e4 times 50.
    always_comb begin
        degp_next = OUT_W'(DP_W'(deg) * DP_W'(DEG_SCALE));
        m50_next  = M50_W'(minutes) * M50_W'(MIN_MULT);
    end

    // Division by three through the rounded-up reciprocal of 2^33 / 3.
    always_comb begin
        recip_prod = (M50_W+32)'(m50_reg) * (M50_W+32)'(RECIP3);
        quot_next  = QUOT_W'(recip_prod >> RECIP_SH);
    end

    always_ff @(posedge aclk) begin
        if (load_mult) begin
            degp_reg <= degp_next;
            m50_reg  <= m50_next;
            neg2_reg <= negative;
        end
        if (load_div) begin
            degp3_reg <= degp_reg;
            quot_reg  <= quot_next;
            neg3_reg  <= neg2_reg;
        end
    end

    // Sum and apply the hemisphere sign.
    always_comb begin
        mag   = degp3_reg + OUT_W'(quot_reg);
        coord = neg3_reg ? (~mag + OUT_W'(1)) : mag;
    end

endmodule
